@@ sv/lzss_byte_decompressor_macros.svh @@
// assertion macros for the lzss byte decompressor
// expects clk and rst_n in the scope where the macros are used
`ifndef LZSS_BYTE_DECOMPRESSOR_MACROS_SVH
`define LZSS_BYTE_DECOMPRESSOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LZBD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lzbd: same-cycle check failed");
`define LZBD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lzbd: next-cycle check failed");
`else
`define LZBD_ASSERT_IMPL(lbl, ante, cons)
`define LZBD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/lzbd_pkg.sv @@
// shared types and constants for the lzss byte decompressor
// no dependencies
`default_nettype none
package lzbd_pkg;

  localparam int WIN_AW    = 12;
  localparam int WIN_DEPTH = 4096;
  localparam int FILL_W    = WIN_AW + 1;
  localparam int CNT_W     = 5;
  localparam logic [3:0] FLAGS_PER_HEADER = 4'd8;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_TOKEN  = 2'd1,
    PH_HIGH   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    IC_NONE = 2'd0,
    IC_LIT  = 2'd1,
    IC_COPY = 2'd2,
    IC_END  = 2'd3
  } item_class_t;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_LIT     = 3'd1,
    ST_COPY_RD = 3'd2,
    ST_COPY_WR = 3'd3,
    ST_END     = 3'd4
  } ctl_state_t;

  typedef struct packed {
    logic accept;
    logic rd;
    logic emit_lit;
    logic emit_copy;
    logic emit_end;
  } dp_cmd_t;

  typedef struct packed {
    item_class_t cls;
    logic        slot_free;
    logic        copy_last;
  } dp_status_t;

endpackage
`default_nettype wire

@@ sv/lzss_if.sv @@
// valid/ready channel interfaces for the lzss byte decompressor
// no dependencies
`default_nettype none
interface lzss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_of_stream;

  modport source (output valid, in_byte, start_of_stream, input ready);
  modport sink (input valid, in_byte, start_of_stream, output ready);
endinterface

interface lzss_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       stream_end;

  modport source (output valid, out_byte, last_of_run, stream_end, input ready);
  modport sink (input valid, out_byte, last_of_run, stream_end, output ready);
endinterface
`default_nettype wire

@@ sv/lzbd_ctrl.sv @@
// sequencing controller for the lzss byte decompressor
// depends on lzbd_pkg
`default_nettype none
module lzbd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire lzbd_pkg::dp_status_t status,
  output lzbd_pkg::dp_cmd_t       cmd
);

  lzbd_pkg::ctl_state_t st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= lzbd_pkg::ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    cmd      = '0;
    in_ready = 1'b0;
    unique case (st_r)
      lzbd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (status.cls)
            lzbd_pkg::IC_LIT:  st_nxt = lzbd_pkg::ST_LIT;
            lzbd_pkg::IC_COPY: st_nxt = lzbd_pkg::ST_COPY_RD;
            lzbd_pkg::IC_END:  st_nxt = lzbd_pkg::ST_END;
            default:           st_nxt = lzbd_pkg::ST_IDLE;
          endcase
        end
      end
      lzbd_pkg::ST_LIT: begin
        if (status.slot_free) begin
          cmd.emit_lit = 1'b1;
          st_nxt       = lzbd_pkg::ST_IDLE;
        end
      end
      lzbd_pkg::ST_COPY_RD: begin
        cmd.rd = 1'b1;
        st_nxt = lzbd_pkg::ST_COPY_WR;
      end
      lzbd_pkg::ST_COPY_WR: begin
        if (status.slot_free) begin
          cmd.emit_copy = 1'b1;
          st_nxt = status.copy_last ? lzbd_pkg::ST_IDLE : lzbd_pkg::ST_COPY_RD;
        end
      end
      lzbd_pkg::ST_END: begin
        if (status.slot_free) begin
          cmd.emit_end = 1'b1;
          st_nxt       = lzbd_pkg::ST_IDLE;
        end
      end
      default: st_nxt = lzbd_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ sv/lzbd_dp.sv @@
// parser registers, history window and output register of the decompressor
// depends on lzbd_pkg
`default_nettype none
module lzbd_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lzbd_pkg::dp_cmd_t  cmd,
  output lzbd_pkg::dp_status_t    status,
  input  wire logic [7:0]         in_byte,
  input  wire logic               in_sos,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [7:0]              out_byte,
  output logic                    out_last,
  output logic                    out_end
);

  localparam int AW = lzbd_pkg::WIN_AW;
  localparam int FW = lzbd_pkg::FILL_W;
  localparam int CW = lzbd_pkg::CNT_W;
  localparam logic [FW-1:0] FILL_FULL = FW'(lzbd_pkg::WIN_DEPTH);

  // parser state
  lzbd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]       flags_r, flags_nxt;
  logic [3:0]       frem_r, frem_nxt;
  logic [7:0]       pend_r, pend_nxt;
  logic             fin_r, fin_nxt;
  logic [AW-1:0]    wp_r, wp_nxt;
  logic [FW-1:0]    fill_r, fill_nxt;

  // copy and literal working registers
  logic [AW-1:0]    pos_r, pos_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [7:0]       lit_r, lit_nxt;
  logic [7:0]       rdata_r;
  logic             rvalid_r;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_end_r, out_end_nxt;

  logic [7:0]       win_mem [lzbd_pkg::WIN_DEPTH];

  lzbd_pkg::phase_t eff_phase;
  logic             eff_fin;
  logic [AW-1:0]    hi_pos;
  logic             wr_en;
  logic [7:0]       wr_data;
  logic [FW-1:0]    fill_inc;
  logic [FW-1:0]    pos_ext;
  logic [3:0]       frem_dec;

  // start of stream clears the parser before the byte is decoded
  assign eff_phase = in_sos ? lzbd_pkg::PH_HEADER : phase_r;
  assign eff_fin   = in_sos ? 1'b0 : fin_r;
  assign hi_pos    = {in_byte[7:4], pend_r};
  assign frem_dec  = frem_r - 4'd1;

  always_comb begin
    status.cls       = lzbd_pkg::IC_NONE;
    status.slot_free = !out_valid_r || out_ready;
    status.copy_last = (cnt_r == '0);
    if (!eff_fin) begin
      unique case (eff_phase)
        lzbd_pkg::PH_TOKEN:
          status.cls = flags_r[0] ? lzbd_pkg::IC_LIT : lzbd_pkg::IC_NONE;
        lzbd_pkg::PH_HIGH:
          status.cls = (hi_pos == '0) ? lzbd_pkg::IC_END : lzbd_pkg::IC_COPY;
        default:
          status.cls = lzbd_pkg::IC_NONE;
      endcase
    end
  end

  // entries past the bytes written since the clear read as zero
  assign fill_inc = (fill_r == FILL_FULL) ? fill_r : fill_r + FW'(1);
  assign pos_ext  = (pos_r == '0) ? FILL_FULL : {1'b0, pos_r};

  assign wr_en   = cmd.emit_lit || cmd.emit_copy;
  assign wr_data = cmd.emit_lit ? lit_r : (rvalid_r ? rdata_r : 8'd0);

  always_comb begin
    phase_nxt = phase_r;
    flags_nxt = flags_r;
    frem_nxt  = frem_r;
    pend_nxt  = pend_r;
    fin_nxt   = fin_r;
    wp_nxt    = wp_r;
    fill_nxt  = fill_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    lit_nxt   = lit_r;
    if (cmd.accept) begin
      if (in_sos) begin
        phase_nxt = lzbd_pkg::PH_HEADER;
        flags_nxt = '0;
        frem_nxt  = '0;
        pend_nxt  = '0;
        fin_nxt   = 1'b0;
        wp_nxt    = AW'(1);
        fill_nxt  = '0;
      end
      if (!eff_fin) begin
        unique case (eff_phase)
          lzbd_pkg::PH_TOKEN: begin
            if (flags_r[0]) begin
              lit_nxt   = in_byte;
              flags_nxt = {1'b0, flags_r[7:1]};
              frem_nxt  = frem_dec;
              phase_nxt = (frem_dec == '0) ? lzbd_pkg::PH_HEADER : lzbd_pkg::PH_TOKEN;
            end else begin
              pend_nxt  = in_byte;
              phase_nxt = lzbd_pkg::PH_HIGH;
            end
          end
          lzbd_pkg::PH_HIGH: begin
            if (hi_pos == '0) begin
              fin_nxt   = 1'b1;
              phase_nxt = lzbd_pkg::PH_HEADER;
            end else begin
              pos_nxt   = hi_pos;
              cnt_nxt   = {1'b0, in_byte[3:0]} + CW'(1);
              flags_nxt = {1'b0, flags_r[7:1]};
              frem_nxt  = frem_dec;
              phase_nxt = (frem_dec == '0) ? lzbd_pkg::PH_HEADER : lzbd_pkg::PH_TOKEN;
            end
          end
          default: begin
            flags_nxt = in_byte;
            frem_nxt  = lzbd_pkg::FLAGS_PER_HEADER;
            phase_nxt = lzbd_pkg::PH_TOKEN;
          end
        endcase
      end
    end
    if (wr_en) begin
      wp_nxt   = wp_r + AW'(1);
      fill_nxt = fill_inc;
    end
    if (cmd.emit_copy) begin
      pos_nxt = pos_r + AW'(1);
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_end_nxt   = out_end_r;
    if (cmd.emit_lit || cmd.emit_copy) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = wr_data;
      out_last_nxt  = cmd.emit_lit || status.copy_last;
      out_end_nxt   = 1'b0;
    end else if (cmd.emit_end) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = 8'd0;
      out_last_nxt  = 1'b1;
      out_end_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= lzbd_pkg::PH_HEADER;
      flags_r     <= '0;
      frem_r      <= '0;
      pend_r      <= '0;
      fin_r       <= 1'b0;
      wp_r        <= AW'(1);
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      flags_r     <= flags_nxt;
      frem_r      <= frem_nxt;
      pend_r      <= pend_nxt;
      fin_r       <= fin_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    cnt_r      <= cnt_nxt;
    lit_r      <= lit_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_end_r  <= out_end_nxt;
    if (cmd.rd) begin
      rvalid_r <= (pos_ext <= fill_r);
    end
  end

  // history window, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      win_mem[wp_r] <= wr_data;
    end
    if (cmd.rd) begin
      rdata_r <= win_mem[pos_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;
  assign out_end   = out_end_r;

endmodule
`default_nettype wire

@@ sv/lzss_byte_decompressor.sv @@
// top level of the lzss byte decompressor with a 4096-byte history window
// depends on lzbd_pkg, lzss_if, lzbd_ctrl, lzbd_dp and the assertion macros
//
// usage:
//   in_ch carries one compressed byte per transfer, with start_of_stream
//   high on the first byte of a stream, which is its first header byte
//   out_ch carries decompressed bytes; last_of_run marks the final result
//   of one input byte, stream_end marks the end result (byte zero)
// sequence:
//   header and reference low bytes: accepted in the idle state, no result
//   literal: latched on transfer, then emitted from the literal state into
//   the window and the output register once the output slot is free
//   reference: 2 to 17 copied bytes; the window memory is read and then
//   written once per copied byte
// reset and clear:
//   window contents are tracked by a fill count, so reset and
//   start_of_stream take effect at once with no clearing pass
// backpressure:
//   one output register; a stalled receiver holds the sequencer in its
//   emit state, and in_ch.ready is low until the current byte is done
`default_nettype none
`include "lzss_byte_decompressor_macros.svh"
module lzss_byte_decompressor (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lzss_in_if.sink     in_ch,
  lzss_out_if.source  out_ch
);

  lzbd_pkg::dp_cmd_t    dp_cmd;
  lzbd_pkg::dp_status_t dp_status;
  logic                 out_valid;
  logic [7:0]           out_byte;
  logic                 out_last;
  logic                 out_end;

  // sequencer: accepts input bytes, steps literal, copy and end emission
  lzbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (dp_status),
    .cmd      (dp_cmd)
  );

  // parser registers, window memory and output register
  lzbd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (dp_cmd),
    .status    (dp_status),
    .in_byte   (in_ch.in_byte),
    .in_sos    (in_ch.start_of_stream),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_end   (out_end)
  );

  assign out_ch.valid       = out_valid;
  assign out_ch.out_byte    = out_byte;
  assign out_ch.last_of_run = out_last;
  assign out_ch.stream_end  = out_end;

  // end result is a lone zero byte closing its run
  `LZBD_ASSERT_IMPL(a_end_shape, out_valid && out_end, out_last && out_byte == 8'd0)
  // a window read is always followed by its write step, never by a new input
  `LZBD_ASSERT_NEXT(a_rd_then_wr, dp_cmd.rd, !in_ch.ready)
  // every emit lands in the output register
  `LZBD_ASSERT_NEXT(a_emit_lands, dp_cmd.emit_lit || dp_cmd.emit_copy || dp_cmd.emit_end, out_ch.valid)
  // bytes that give no result leave the block ready for the next one
  `LZBD_ASSERT_NEXT(a_no_result_ready, dp_cmd.accept && dp_status.cls == lzbd_pkg::IC_NONE, in_ch.ready)

endmodule
`default_nettype wire
